@@ rtl/rssc_pkg.sv @@
package rssc_pkg;

  localparam int MaxSyndromesDefault = 64;

  localparam int SymW = 16;
  localparam int IdxW = 6;
  localparam int CntW = 7;

  // x^16 + x^12 + x^3 + x + 1
  localparam logic [SymW:0] FieldPoly = 17'o210013;

  localparam logic [CntW-1:0] NumSyndReset = 7'd16;

  // register map, index = paddr[2]
  localparam int AddrW = 3;
  localparam logic RegNumSynd = 1'b0;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last;
  } in_beat_t;

  typedef struct packed {
    logic [IdxW-1:0] syndrome_index;
    logic [SymW-1:0] syndrome_value;
    logic            final_syndrome;
  } out_beat_t;

  // per-cell control, driven from the top-level sequencer
  typedef struct packed {
    logic load;   // Horner step with the incoming symbol
    logic shift;  // take the neighbor's accumulator
    logic clear;  // zero the accumulator
  } cell_ctrl_t;

  function automatic logic [SymW-1:0] gf_times_alpha(input logic [SymW-1:0] v);
    logic [SymW:0] w;
    w = {v, 1'b0};
    if (w[SymW]) begin
      w = w ^ FieldPoly;
    end
    return w[SymW-1:0];
  endfunction

  // shift-and-add product; with b constant this folds to an XOR network
  function automatic logic [SymW-1:0] gf_mul(input logic [SymW-1:0] a,
                                            input logic [SymW-1:0] b);
    logic [SymW-1:0] acc;
    logic [SymW-1:0] p;
    acc = '0;
    p   = a;
    for (int k = 0; k < SymW; k++) begin
      if (b[k]) begin
        acc = acc ^ p;
      end
      p = gf_times_alpha(p);
    end
    return acc;
  endfunction

  // alpha^n, evaluated at elaboration
  function automatic logic [SymW-1:0] gf_alpha_pow(input int n);
    logic [SymW-1:0] r;
    r = {{(SymW-1){1'b0}}, 1'b1};
    for (int k = 0; k < n; k++) begin
      r = gf_times_alpha(r);
    end
    return r;
  endfunction

endpackage

@@ rtl/rssc_cell.sv @@
module rssc_cell #(
  parameter logic [rssc_pkg::SymW-1:0] Root = 16'h0002
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rssc_pkg::cell_ctrl_t      ctrl_i,
  input  logic [rssc_pkg::SymW-1:0] symbol_i,
  input  logic [rssc_pkg::SymW-1:0] nbr_acc_i,
  output logic [rssc_pkg::SymW-1:0] acc_o
);

  logic [rssc_pkg::SymW-1:0] acc_q;
  logic [rssc_pkg::SymW-1:0] acc_d;

  always_comb begin
    acc_d = acc_q;
    priority if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.load) begin
      acc_d = rssc_pkg::gf_mul(acc_q, Root) ^ symbol_i;
    end else if (ctrl_i.shift) begin
      acc_d = nbr_acc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ rtl/rs_syndrome_calculator.sv @@
// Reed-Solomon syndrome calculator over GF(2^16), field polynomial
// x^16+x^12+x^3+x+1, alpha = 2. Symbols come in highest power first, one
// per input beat, and each accepted input beat steps every cell at once:
// a row of MAX_SYNDROMES cells, cell i holding syndrome i and multiplying
// by the constant alpha^(i+1) in the same cycle. A beat with last set ends
// the codeword; the block then sends num_syndromes output beats (clamped to
// 2..MAX_SYNDROMES), index 0 first, final_syndrome set on the last one.
// The drain shifts the row of cells toward cell 0, one output beat per
// cycle while out_ready_i is high; the cells clear on the edge that takes
// the final syndrome beat, so the next codeword can start in the following
// cycle. in_ready_o is low from the last symbol until the final syndrome
// beat has been taken. num_syndromes sits at byte address 0 of the APB
// port (reset 16); writes elsewhere are dropped.
module rs_syndrome_calculator #(
  parameter int MAX_SYNDROMES = rssc_pkg::MaxSyndromesDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // codeword symbols
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rssc_pkg::in_beat_t         in_data_i,
  // syndromes
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rssc_pkg::out_beat_t        out_data_o,
  // APB config port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rssc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int CntW = rssc_pkg::CntW;
  localparam int IdxW = rssc_pkg::IdxW;
  localparam int SymW = rssc_pkg::SymW;

  // ---------------------------------------------------------------------
  // Config register
  // ---------------------------------------------------------------------
  logic [CntW-1:0] num_synd_q;
  logic [CntW-1:0] num_synd_d;
  logic            reg_sel;

  assign reg_sel = (paddr[2] == rssc_pkg::RegNumSynd);
  assign pready  = 1'b1;

  always_comb begin
    num_synd_d = num_synd_q;
    if (psel && penable && pwrite && reg_sel) begin
      num_synd_d = pwdata[CntW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(32-CntW){1'b0}}, num_synd_q};
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: accumulate, then drain through cell 0
  // ---------------------------------------------------------------------
  logic            draining_q, draining_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] count_clamped;
  logic            in_fire, out_fire, is_final;
  rssc_pkg::cell_ctrl_t ctrl;

  assign in_ready_o  = !draining_q;
  assign out_valid_o = draining_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;
  assign is_final    = ({1'b0, idx_q} == (count_q - CntW'(1)));

  // out-of-range register values saturate
  always_comb begin
    priority if (num_synd_q < CntW'(2)) begin
      count_clamped = CntW'(2);
    end else if (num_synd_q > CntW'(MAX_SYNDROMES)) begin
      count_clamped = CntW'(MAX_SYNDROMES);
    end else begin
      count_clamped = num_synd_q;
    end
  end

  always_comb begin
    draining_d = draining_q;
    idx_d      = idx_q;
    count_d    = count_q;
    ctrl       = '0;
    if (in_fire) begin
      ctrl.load = 1'b1;
      if (in_data_i.last) begin
        draining_d = 1'b1;
        idx_d      = '0;
        count_d    = count_clamped;
      end
    end
    if (out_fire) begin
      if (is_final) begin
        draining_d = 1'b0;
        ctrl.clear = 1'b1;   // every cell back to zero for the next codeword
      end else begin
        idx_d      = idx_q + IdxW'(1);
        ctrl.shift = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_synd_q <= rssc_pkg::NumSyndReset;
      draining_q <= 1'b0;
      idx_q      <= '0;
      count_q    <= CntW'(2);
    end else begin
      num_synd_q <= num_synd_d;
      draining_q <= draining_d;
      idx_q      <= idx_d;
      count_q    <= count_d;
    end
  end

  // ---------------------------------------------------------------------
  // Row of syndrome cells; cell i evaluates at alpha^(i+1) and, during the
  // drain, takes the accumulator of cell i+1.
  // ---------------------------------------------------------------------
  logic [SymW-1:0] acc [MAX_SYNDROMES+1];

  assign acc[MAX_SYNDROMES] = '0;  // zeros enter the far end on a shift

  for (genvar g = 0; g < MAX_SYNDROMES; g++) begin : g_cell
    rssc_cell #(
      .Root(rssc_pkg::gf_alpha_pow(g + 1))
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .symbol_i (in_data_i.symbol),
      .nbr_acc_i(acc[g+1]),
      .acc_o    (acc[g])
    );
  end

  assign out_data_o.syndrome_index = idx_q;
  assign out_data_o.syndrome_value = acc[0];
  assign out_data_o.final_syndrome = is_final;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  // Cells in the block; the instance keeps its default size.
  localparam int NumCells = rssc_pkg::MaxSyndromesDefault;
  localparam int CntW     = rssc_pkg::CntW;
  localparam int IdxW     = rssc_pkg::IdxW;
  localparam int AddrW    = rssc_pkg::AddrW;
  // Field polynomial x^16 + x^12 + x^3 + x + 1, kept locally for the predictor.
  localparam logic [16:0] GfPoly = 17'h1100B;

  // Register map: the register index sits in paddr[2].
  localparam logic [AddrW-1:0] AddrNumSynd = {rssc_pkg::RegNumSynd, 2'b00};
  localparam logic [AddrW-1:0] AddrNoReg   = {~rssc_pkg::RegNumSynd, 2'b00};

  // Slack after the last syndrome beat before the block is called idle.
  localparam int DrainSlack = 8;
  // Cycles with no beat on either channel before the run is called hung.
  localparam int HangLimit  = 500;
  // Random symbols after the directed tests.
  localparam int RandItems  = 445;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  rssc_pkg::in_beat_t  in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  rssc_pkg::out_beat_t out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  rs_syndrome_calculator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // ---------------------------------------------------------------------------
  // Syndrome predictor state: one Horner accumulator per cell, the evaluation
  // point alpha^(i+1) of each cell, and a shadow of num_syndromes.
  // ---------------------------------------------------------------------------
  logic [15:0]         horner_acc [NumCells];
  logic [15:0]         eval_point [NumCells];
  logic [CntW-1:0]     num_synd_shadow;
  rssc_pkg::out_beat_t expected_syndromes[$];

  int  mismatch_count;
  int  hang_count;
  bit  in_gap_en;     // random gaps on the symbol side
  bit  out_stall_en;  // random stalls on the syndrome side

  // Carry-less product, then fold the upper half back with the polynomial.
  function automatic logic [15:0] gf_multiply(input logic [15:0] a, input logic [15:0] b);
    logic [30:0] prod;
    prod = '0;
    for (int k = 0; k < 16; k++) begin
      if (b[k]) begin
        prod = prod ^ (31'(a) << k);
      end
    end
    for (int k = 30; k >= 16; k--) begin
      if (prod[k]) begin
        prod = prod ^ (31'(GfPoly) << (k - 16));
      end
    end
    return prod[15:0];
  endfunction

  // One accepted symbol: every cell steps, whatever the register holds.
  // On the closing symbol the first num_syndromes cells are queued as
  // expected beats (register clamped to 2..NumCells), then all cells clear.
  task automatic absorb_symbol(input logic [15:0] sym, input logic lst);
    int                  count;
    rssc_pkg::out_beat_t beat;
    for (int i = 0; i < NumCells; i++) begin
      horner_acc[i] = gf_multiply(horner_acc[i], eval_point[i]) ^ sym;
    end
    if (lst) begin
      count = int'(num_synd_shadow);
      if (count < 2) count = 2;
      if (count > NumCells) count = NumCells;
      for (int i = 0; i < count; i++) begin
        beat.syndrome_index = IdxW'(i);
        beat.syndrome_value = horner_acc[i];
        beat.final_syndrome = (i == count - 1);
        expected_syndromes.push_back(beat);
      end
      for (int i = 0; i < NumCells; i++) begin
        horner_acc[i] = '0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Symbol side: optional random gap, then hold the beat until taken.
  // valid stays high between back-to-back beats, so it is never dropped and
  // raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_symbol(input logic [15:0] sym, input logic lst);
    rssc_pkg::in_beat_t beat;
    beat.symbol = sym;
    beat.last   = lst;
    if (in_gap_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    absorb_symbol(sym, lst);
  endtask

  // Drop valid, wait for every queued syndrome, then the DrainSlack margin so
  // the block is idle before a register write.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (expected_syndromes.size() != 0) @(posedge clk_i);
    repeat (DrainSlack) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle; lands when pready is seen.
  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == rssc_pkg::RegNumSynd) begin
      num_synd_shadow = data[CntW-1:0];
    end
  endtask

  task automatic set_num_synd(input logic [31:0] data);
    settle_block();
    apb_write(AddrNumSynd, data);
  endtask

  // ---------------------------------------------------------------------------
  // Syndrome side: when stalls are enabled, ready drops for random bursts,
  // with runs of ready high in between.
  // ---------------------------------------------------------------------------
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (out_stall_en && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every accepted syndrome beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : p_check
    rssc_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_syndromes.size() == 0) begin
        $display("%0t: unexpected syndrome beat idx %0d value %h final %b", $time,
                 out_data_o.syndrome_index, out_data_o.syndrome_value,
                 out_data_o.final_syndrome);
        mismatch_count++;
      end else begin
        want = expected_syndromes.pop_front();
        if (out_data_o.syndrome_index !== want.syndrome_index) begin
          $display("%0t: syndrome_index expected %0d actual %0d", $time,
                   want.syndrome_index, out_data_o.syndrome_index);
          mismatch_count++;
        end
        if (out_data_o.syndrome_value !== want.syndrome_value) begin
          $display("%0t: syndrome_value (idx %0d) expected %h actual %h", $time,
                   want.syndrome_index, want.syndrome_value, out_data_o.syndrome_value);
          mismatch_count++;
        end
        if (out_data_o.final_syndrome !== want.final_syndrome) begin
          $display("%0t: final_syndrome (idx %0d) expected %b actual %b", $time,
                   want.syndrome_index, want.final_syndrome, out_data_o.final_syndrome);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without a beat on either channel means a hang.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      hang_count = 0;
    end else begin
      hang_count++;
      if (hang_count >= HangLimit) begin
        $display("%0t: no beat for %0d cycles", $time, HangLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Register still at its reset value of 16; includes a one-symbol codeword.
  task automatic test_reset_default();
    send_symbol(16'hFFFF, 1'b0);
    send_symbol(16'h0001, 1'b0);
    send_symbol(16'h8000, 1'b0);
    send_symbol(16'h1234, 1'b1);
    send_symbol(16'hA5A5, 1'b1);
  endtask

  // All-zero and all-one symbols with every cell emitted.
  task automatic test_symbol_extremes();
    set_num_synd(32'd64);
    send_symbol(16'h0000, 1'b0);
    send_symbol(16'h0000, 1'b1);
    send_symbol(16'hFFFF, 1'b0);
    send_symbol(16'hFFFF, 1'b1);
  endtask

  // Below-range values act as 2, above-range values as the cell count, and
  // a write to the unmapped address leaves the register alone.
  task automatic test_register_clamp();
    set_num_synd(32'd0);
    send_symbol(16'h7FFE, 1'b1);
    set_num_synd(32'd1);
    send_symbol(16'h8001, 1'b1);
    set_num_synd(32'd2);
    send_symbol(16'h00FF, 1'b0);
    send_symbol(16'hFF00, 1'b1);
    set_num_synd(32'd65);
    send_symbol(16'h5A5A, 1'b1);
    set_num_synd(32'hFFFF_FFFF);  // low bits read 127
    send_symbol(16'hC3C3, 1'b1);
    set_num_synd(32'd5);
    settle_block();
    apb_write(AddrNoReg, 32'd3);
    send_symbol(16'h0F0F, 1'b1);
  endtask

  // Register changed between symbols of one codeword: the value at the
  // closing symbol decides the count.
  task automatic test_mid_codeword_write();
    set_num_synd(32'd40);
    send_symbol(16'h1357, 1'b0);
    send_symbol(16'h2468, 1'b0);
    send_symbol(16'h9BDF, 1'b0);
    set_num_synd(32'd3);
    send_symbol(16'hECA8, 1'b1);
  endtask

  // Random codewords, mostly short with some long ones, across a series of
  // register settings. Idling is switched off near the end.
  task automatic test_random_codewords();
    int          sent;
    int          phase;
    int          len;
    logic [15:0] sym;
    sent  = 0;
    phase = 0;
    while (sent < RandItems) begin
      if (sent >= phase * 60) begin
        case (phase % 4)
          0: set_num_synd(32'd64);
          1: set_num_synd(32'd2);
          2: set_num_synd($urandom_range(2, 64));
          default: set_num_synd($urandom());  // full word, junk in upper bits
        endcase
        in_gap_en    = (phase % 3 != 2);
        out_stall_en = (phase % 3 != 1);
        phase++;
      end
      if (sent >= RandItems - 60) begin
        in_gap_en    = 1'b0;
        out_stall_en = 1'b0;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 9))
          0: sym = 16'h0000;
          1: sym = 16'hFFFF;
          default: sym = 16'($urandom());
        endcase
        send_symbol(sym, k == len - 1);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatch_count  = 0;
    hang_count      = 0;
    in_gap_en       = 1'b1;
    out_stall_en    = 1'b1;
    num_synd_shadow = rssc_pkg::NumSyndReset;
    eval_point[0]   = 16'h0002;
    for (int i = 1; i < NumCells; i++) begin
      eval_point[i] = gf_multiply(eval_point[i-1], 16'h0002);
    end
    for (int i = 0; i < NumCells; i++) begin
      horner_acc[i] = '0;
    end

    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_default();
    test_symbol_extremes();
    test_register_clamp();
    test_mid_codeword_write();
    test_random_codewords();

    settle_block();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
